FILE: hdl/atbr_pkg.sv
// ----------------------------------------------------------------------------
// atbr_pkg
// Shared constants, register codes and types of the beat rate detector.
// ----------------------------------------------------------------------------
package atbr_pkg;

  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int INTERVAL_BITS_DEF = 16;
  localparam int RATE_BITS         = 16;
  localparam int TOTAL_BITS        = 16;
  localparam int WLEN_BITS         = 10;
  localparam int CFG_DATA_BITS     = 16;
  localparam int CFG_INDEX_BITS    = 1;
  localparam int STEP_BITS         = $clog2(RATE_BITS);

  localparam logic [WLEN_BITS-1:0] WLEN_RESET  = WLEN_BITS'(100);
  localparam logic [RATE_BITS-1:0] SCALE_RESET = RATE_BITS'(6000);
  localparam logic [STEP_BITS-1:0] STEP_LAST   = STEP_BITS'(RATE_BITS - 1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_BPM_SCALE     = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WRITE
  } back_state_t;

  typedef struct packed {
    logic beat;
    logic updated;
  } entry_flags_t;

endpackage

FILE: hdl/atbr_ifs.sv
// ----------------------------------------------------------------------------
// atbr channel interfaces
// Sample, result and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface atbr_sample_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface atbr_result_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   beat;
  logic [15:0]            rate_bpm;
  logic [15:0]            beat_total;
  logic                   level_updated;
  logic [SAMPLE_BITS:0]   level_doubled;

  modport source (output valid, output beat, output rate_bpm, output beat_total,
                  output level_updated, output level_doubled, input ready);
  modport sink   (input valid, input beat, input rate_bpm, input beat_total,
                  input level_updated, input level_doubled, output ready);
endinterface

interface atbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/adaptive_threshold_beat_rate_top.sv
// ----------------------------------------------------------------------------
// adaptive_threshold_beat_rate_top
// Adaptive midpoint threshold beat detector with beats-per-minute estimate.
// ----------------------------------------------------------------------------
// Every sample gives one result. The front end classifies a sample in the
// cycle it is taken and places it in a two-entry queue; the back end passes
// a sample without a beat to the output register, while a beat runs a
// restoring divider of bpm_scale by the sample interval, one quotient bit
// per cycle, and holds the back end until the rate is written out. Between
// beats the sustained rate is one sample per cycle while the output is not
// stalled. The configuration channel is always ready; write it only while
// no sample is in flight.
module adaptive_threshold_beat_rate_top import atbr_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  atbr_sample_if.sink   samples,
  atbr_result_if.source results,
  atbr_cfg_if.sink      cfg
);

  localparam int ENTRY_W = 2 + (SAMPLE_BITS + 1) + INTERVAL_BITS;

  logic [WLEN_BITS-1:0]     window_length;
  logic [RATE_BITS-1:0]     bpm_scale;

  logic                     push;
  logic                     pop;
  logic                     full;
  logic                     empty;
  entry_flags_t             front_flags;
  logic [SAMPLE_BITS:0]     front_level;
  logic [INTERVAL_BITS-1:0] front_interval;
  logic [ENTRY_W-1:0]       head_data;
  entry_flags_t             head_flags;
  logic [SAMPLE_BITS:0]     head_level;
  logic [INTERVAL_BITS-1:0] head_interval;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
      bpm_scale     <= SCALE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_WINDOW_LENGTH: window_length <= cfg.data[WLEN_BITS-1:0];
        REG_BPM_SCALE:     bpm_scale     <= cfg.data[RATE_BITS-1:0];
      endcase
    end
  end

  atbr_front #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .sample        (samples.sample),
    .window_length (window_length),
    .full          (full),
    .push          (push),
    .flags         (front_flags),
    .level         (front_level),
    .interval      (front_interval)
  );

  atbr_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({front_flags, front_level, front_interval}),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head_data (head_data)
  );

  assign {head_flags, head_level, head_interval} = head_data;

  atbr_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (!empty),
    .head_flags    (head_flags),
    .head_level    (head_level),
    .head_interval (head_interval),
    .pop           (pop),
    .bpm_scale     (bpm_scale),
    .results       (results)
  );

endmodule

FILE: hdl/atbr_front.sv
// ----------------------------------------------------------------------------
// atbr_front
// Window min/max tracking, threshold update, crossing test, interval count.
// ----------------------------------------------------------------------------
module atbr_front import atbr_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic [WLEN_BITS-1:0]     window_length,
  input  logic                     full,
  output logic                     push,
  output entry_flags_t             flags,
  output logic [SAMPLE_BITS:0]     level,
  output logic [INTERVAL_BITS-1:0] interval
);

  logic [SAMPLE_BITS-1:0]   window_min;
  logic [SAMPLE_BITS-1:0]   window_max;
  logic [SAMPLE_BITS:0]     level_sum;
  logic [WLEN_BITS-1:0]     window_count;
  logic [SAMPLE_BITS-1:0]   last_sample;
  logic [INTERVAL_BITS-1:0] interval_count;

  logic [SAMPLE_BITS-1:0]   min_upd;
  logic [SAMPLE_BITS-1:0]   max_upd;
  logic                     recalc;
  logic [SAMPLE_BITS:0]     level_next;
  logic [INTERVAL_BITS-1:0] interval_inc;
  logic                     beat_now;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  always_comb begin
    min_upd      = (sample < window_min) ? sample : window_min;
    max_upd      = (sample > window_max) ? sample : window_max;
    recalc       = (window_count >= window_length);
    level_next   = recalc ? ({1'b0, max_upd} + {1'b0, min_upd}) : level_sum;
    interval_inc = (interval_count != '1) ? interval_count + 1'b1 : interval_count;
    beat_now     = ({sample, 1'b0} > level_next) && ({last_sample, 1'b0} <= level_next);
  end

  assign flags.beat    = beat_now;
  assign flags.updated = recalc;
  assign level         = level_next;
  assign interval      = interval_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_min     <= '1;
      window_max     <= '0;
      level_sum      <= '0;
      window_count   <= '0;
      last_sample    <= '0;
      interval_count <= '0;
    end else if (push) begin
      window_min     <= recalc ? '1 : min_upd;
      window_max     <= recalc ? '0 : max_upd;
      level_sum      <= level_next;
      window_count   <= (recalc ? '0 : window_count) + 1'b1;
      last_sample    <= sample;
      interval_count <= beat_now ? '0 : interval_inc;
    end
  end

endmodule

FILE: hdl/atbr_queue.sv
// ----------------------------------------------------------------------------
// atbr_queue
// Two-entry queue between the classifying front and the rate back end.
// ----------------------------------------------------------------------------
module atbr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full      = (fill == 2'd2);
  assign empty     = (fill == 2'd0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: hdl/atbr_back.sv
// ----------------------------------------------------------------------------
// atbr_back
// Serial rate divider, beat total and registered result output.
// ----------------------------------------------------------------------------
module atbr_back import atbr_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     head_valid,
  input  entry_flags_t             head_flags,
  input  logic [SAMPLE_BITS:0]     head_level,
  input  logic [INTERVAL_BITS-1:0] head_interval,
  output logic                     pop,
  input  logic [RATE_BITS-1:0]     bpm_scale,
  atbr_result_if.source            results
);

  back_state_t state;
  back_state_t state_next;

  logic                     out_valid;
  logic                     out_beat;
  logic                     out_updated;
  logic [SAMPLE_BITS:0]     out_level;
  logic [RATE_BITS-1:0]     held_rate;
  logic [TOTAL_BITS-1:0]    beats_seen;

  logic [INTERVAL_BITS-1:0] divisor;
  logic [INTERVAL_BITS-1:0] rem;
  logic [RATE_BITS-1:0]     quo;
  logic [STEP_BITS-1:0]     step;

  logic                     out_free;
  logic                     start;
  logic                     iterate;
  logic                     load;

  logic [INTERVAL_BITS:0]   trial;
  logic                     fits;

  assign out_free = !out_valid || results.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid && head_flags.beat) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step == STEP_LAST) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    start   = 1'b0;
    iterate = 1'b0;
    load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        start = head_valid && head_flags.beat;
        load  = head_valid && !head_flags.beat && out_free;
      end
      ST_DIVIDE: iterate = 1'b1;
      ST_WRITE:  load    = out_free;
      default: begin
        start   = 1'b0;
        iterate = 1'b0;
        load    = 1'b0;
      end
    endcase
    pop = load;
  end

  always_comb begin
    trial = {rem, quo[RATE_BITS-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= head_interval;
      rem     <= '0;
      quo     <= bpm_scale;
      step    <= '0;
    end else if (iterate) begin
      rem  <= fits ? INTERVAL_BITS'(trial - {1'b0, divisor}) : INTERVAL_BITS'(trial);
      quo  <= {quo[RATE_BITS-2:0], fits};
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      held_rate  <= '0;
      beats_seen <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      if (head_flags.beat) begin
        held_rate  <= quo;
        beats_seen <= beats_seen + 1'b1;
      end
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_beat    <= head_flags.beat;
      out_updated <= head_flags.updated;
      out_level   <= head_level;
    end
  end

  assign results.valid         = out_valid;
  assign results.beat          = out_beat;
  assign results.rate_bpm      = held_rate;
  assign results.beat_total    = beats_seen;
  assign results.level_updated = out_updated;
  assign results.level_doubled = out_level;

endmodule

FILE: sim/tb_adaptive_threshold_beat_rate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_threshold_beat_rate_top
// Self-checking bench for the adaptive threshold beat rate detector. Samples
// go in over the sample channel and every sample yields one result. An
// in-bench model of the min/max window, midpoint threshold, rising-crossing
// detector and interval divider predicts each result, and a checker compares
// results in order. The bench runs directed corner cases, pulse-shaped random
// traffic under several register settings, output back-pressure and a long
// quiet stretch without beats.
// ----------------------------------------------------------------------------
module tb_adaptive_threshold_beat_rate_top;
  import atbr_pkg::*;

  localparam int     SB             = SAMPLE_BITS_DEF;
  localparam int     DRAIN_CYCLES   = 20;
  localparam int     LONG_HOLD      = 200;
  localparam int     PHASE_ITEMS    = 100;
  localparam int     SILENCE_ITEMS  = 100;
  localparam longint LIMIT_NS       = 4_000_000;
  localparam logic [SB-1:0] FULL_SCALE   = '1;
  localparam logic [15:0]   INTERVAL_TOP = '1;

  typedef struct packed {
    logic                  beat;
    logic [RATE_BITS-1:0]  rate_bpm;
    logic [TOTAL_BITS-1:0] beat_total;
    logic                  level_updated;
    logic [SB:0]           level_doubled;
  } beat_report_t;

  logic clk;
  logic rst;

  atbr_sample_if #(.SAMPLE_BITS(SB)) sample_ch ();
  atbr_result_if #(.SAMPLE_BITS(SB)) result_ch ();
  atbr_cfg_if                        cfg_ch ();

  adaptive_threshold_beat_rate_top DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  // detector model state
  logic [WLEN_BITS-1:0] wlen_cfg;
  logic [RATE_BITS-1:0] scale_cfg;
  logic [SB-1:0]        win_lo;
  logic [SB-1:0]        win_hi;
  logic [SB:0]          level_sum;
  logic [WLEN_BITS-1:0] win_count;
  logic [SB-1:0]        prev_sample;
  logic [15:0]          since_beat;
  logic [RATE_BITS-1:0] rate_held;
  logic [15:0]          beat_tally;

  beat_report_t beat_reports_due[$];
  beat_report_t seen_report;
  int           mismatches;

  bit tx_gaps_on;
  bit rx_stalls_on;
  bit hold_start;
  int hold_left;
  int stall_left;

  int pulse_pos;
  int pulse_period;
  int pulse_base;
  int pulse_peak;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic reset_model();
    wlen_cfg    = WLEN_RESET;
    scale_cfg   = SCALE_RESET;
    win_lo      = FULL_SCALE;
    win_hi      = '0;
    level_sum   = '0;
    win_count   = '0;
    prev_sample = '0;
    since_beat  = '0;
    rate_held   = '0;
    beat_tally  = '0;
  endtask

  function automatic beat_report_t predict_beat(input logic [SB-1:0] s);
    beat_report_t r;
    r = '0;
    if (s < win_lo) win_lo = s;
    if (s > win_hi) win_hi = s;
    if (win_count >= wlen_cfg) begin
      level_sum       = {1'b0, win_hi} + {1'b0, win_lo};
      win_lo          = FULL_SCALE;
      win_hi          = '0;
      win_count       = '0;
      r.level_updated = 1'b1;
    end
    win_count = win_count + 1'b1;
    if (since_beat != INTERVAL_TOP) since_beat = since_beat + 1'b1;
    if (({s, 1'b0} > level_sum) && ({prev_sample, 1'b0} <= level_sum)) begin
      r.beat     = 1'b1;
      rate_held  = scale_cfg / since_beat;
      beat_tally = beat_tally + 1'b1;
      since_beat = '0;
    end
    prev_sample     = s;
    r.rate_bpm      = rate_held;
    r.beat_total    = beat_tally;
    r.level_doubled = level_sum;
    return r;
  endfunction

  // pulse train with random period, baseline and peak, plus some noise
  function automatic logic [SB-1:0] pulse_wave_sample();
    logic [SB-1:0] s;
    if ($urandom_range(0, 99) < 12) return SB'($urandom);
    if (pulse_pos == 0) begin
      pulse_period = $urandom_range(3, 40);
      pulse_base   = $urandom_range(0, 1500);
      pulse_peak   = $urandom_range(2500, 4095);
    end
    if (pulse_pos < 2) s = SB'(pulse_peak - $urandom_range(0, 200));
    else s = SB'(pulse_base + $urandom_range(0, 100));
    pulse_pos = (pulse_pos + 1) % pulse_period;
    return s;
  endfunction

  task automatic send_sample(input logic [SB-1:0] s);
    int gap;
    gap = tx_gaps_on ? idle_gap() : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
    beat_reports_due.push_back(predict_beat(s));
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (beat_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_WINDOW_LENGTH: wlen_cfg  = val[WLEN_BITS-1:0];
      REG_BPM_SCALE:     scale_cfg = val;
      default: ;
    endcase
  endtask

  // result channel ready: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else if (hold_start) begin
      hold_left = LONG_HOLD;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      stall_left = rx_stalls_on ? idle_gap() : 0;
      result_ch.ready <= (stall_left == 0);
    end
  end

  task automatic report_mismatch(input string what, input beat_report_t want,
                                 input beat_report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected beat=%0d rate=%0d total=%0d upd=%0d level=%0d",
               $realtime, what, want.beat, want.rate_bpm, want.beat_total,
               want.level_updated, want.level_doubled,
               " / got beat=%0d rate=%0d total=%0d upd=%0d level=%0d",
               got.beat, got.rate_bpm, got.beat_total, got.level_updated,
               got.level_doubled);
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen_report.beat          = result_ch.beat;
      seen_report.rate_bpm      = result_ch.rate_bpm;
      seen_report.beat_total    = result_ch.beat_total;
      seen_report.level_updated = result_ch.level_updated;
      seen_report.level_doubled = result_ch.level_doubled;
      if (beat_reports_due.size() == 0) begin
        report_mismatch("result with nothing pending", '0, seen_report);
      end else begin
        if (seen_report.beat !== beat_reports_due[0].beat ||
            seen_report.rate_bpm !== beat_reports_due[0].rate_bpm ||
            seen_report.beat_total !== beat_reports_due[0].beat_total ||
            seen_report.level_updated !== beat_reports_due[0].level_updated ||
            seen_report.level_doubled !== beat_reports_due[0].level_doubled)
          report_mismatch("result mismatch", beat_reports_due[0], seen_report);
        void'(beat_reports_due.pop_front());
      end
    end
  end

  task automatic test_startup_threshold();
    logic [SB-1:0] seq[8];
    seq = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd1, 12'd2048, 12'd0, 12'd4094};
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  task automatic test_window_length_edges();
    logic [SB-1:0] lowered[5];
    logic [SB-1:0] per_sample[5];
    lowered    = '{12'd3000, 12'd10, 12'd4095, 12'd0, 12'd2000};
    per_sample = '{12'd5, 12'd4095, 12'd4095, 12'd0, 12'd1};
    // count is past the new length: recompute on the next sample
    write_reg(REG_WINDOW_LENGTH, 16'd3);
    foreach (lowered[i]) send_sample(lowered[i]);
    write_reg(REG_WINDOW_LENGTH, 16'd0);
    foreach (per_sample[i]) send_sample(per_sample[i]);
  endtask

  task automatic test_rate_scale_edges();
    write_reg(REG_WINDOW_LENGTH, 16'd2);
    write_reg(REG_BPM_SCALE, 16'd0);
    repeat (3) begin
      send_sample(12'd0);
      send_sample(12'd4095);
    end
    write_reg(REG_WINDOW_LENGTH, 16'd1);
    write_reg(REG_BPM_SCALE, 16'hFFFF);
    repeat (2) begin
      send_sample(12'd0);
      send_sample(12'd4095);
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] wl;
    logic [15:0] sc;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          wl = 16'd1;
          sc = 16'hFFFF;
        end
        1: begin
          wl = 16'd1023;
          sc = 16'($urandom);
        end
        2: begin
          wl = 16'($urandom_range(2, 20));
          sc = 16'($urandom_range(1, 600));
        end
        3: begin
          // upper data bits are outside the window length field
          wl = {6'($urandom), 10'($urandom_range(1, 60))};
          sc = 16'($urandom);
        end
        default: begin
          wl = 16'($urandom_range(1, 1023));
          sc = 16'($urandom_range(1, 65535));
        end
      endcase
      write_reg(REG_WINDOW_LENGTH, wl);
      write_reg(REG_BPM_SCALE, sc);
      tx_gaps_on = (p != 2);
      rx_stalls_on <= (p != 2);
      repeat (PHASE_ITEMS) send_sample(pulse_wave_sample());
    end
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    write_reg(REG_WINDOW_LENGTH, 16'd8);
    write_reg(REG_BPM_SCALE, 16'd6000);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    tx_gaps_on = 1'b0;
    repeat (40) send_sample(pulse_wave_sample());
    // hold the sender until everything is back
    drain_results();
    tx_gaps_on = 1'b1;
    repeat (20) send_sample(pulse_wave_sample());
  endtask

  task automatic test_long_silence();
    write_reg(REG_WINDOW_LENGTH, 16'd5);
    write_reg(REG_BPM_SCALE, 16'hFFFF);
    tx_gaps_on = 1'b0;
    rx_stalls_on <= 1'b0;
    repeat (SILENCE_ITEMS) send_sample(12'd100);
    repeat (12) send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd0);
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    rst              = 1'b1;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_WINDOW_LENGTH;
    cfg_ch.data      = '0;
    tx_gaps_on       = 1'b1;
    rx_stalls_on     = 1'b1;
    hold_start       = 1'b0;
    mismatches       = 0;
    pulse_pos        = 0;
    pulse_period     = 1;
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_startup_threshold();
    test_window_length_edges();
    test_rate_scale_edges();
    test_backpressure();
    test_random_traffic();
    test_long_silence();

    drain_results();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
